// ===== rtl/core/ack_retry_sender_assert.svh =====
// ---------------------------------------------------------------------------
// ack_retry_sender_assert.svh
// Assertion macros used by the retry sender checker.
// ---------------------------------------------------------------------------
`ifndef ACK_RETRY_SENDER_ASSERT_SVH
`define ACK_RETRY_SENDER_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define ARS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define ARS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define ARS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ars_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ars_pkg
// Types, event codes and result codes of the stop-and-wait retry sender.
// ---------------------------------------------------------------------------
package ars_pkg;

  localparam int AddrW   = 48;
  localparam int TriesW  = 8;
  localparam int TicksW  = 16;
  localparam int FuncW   = 2;
  localparam int ActW    = 3;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 16;

  // Event kinds
  localparam logic [FuncW-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_FRAME = 2'd1;
  localparam logic [FuncW-1:0] FUNC_ACK   = 2'd2;
  localparam logic [FuncW-1:0] FUNC_NONE  = 2'd3;

  // Result actions
  localparam logic [ActW-1:0] ACT_NONE       = 3'd0;
  localparam logic [ActW-1:0] ACT_SEND       = 3'd1;
  localparam logic [ActW-1:0] ACT_RESEND     = 3'd2;
  localparam logic [ActW-1:0] ACT_GAVE_UP    = 3'd3;
  localparam logic [ActW-1:0] ACT_ACKED      = 3'd4;
  localparam logic [ActW-1:0] ACT_UNEXPECTED = 3'd5;
  localparam logic [ActW-1:0] ACT_WRONG      = 3'd6;
  localparam logic [ActW-1:0] ACT_BUSY       = 3'd7;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_TRY_LIMIT     = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS = 1'd1;

  localparam logic [TriesW-1:0] TRY_LIMIT_RST     = 8'd16;
  localparam logic [TicksW-1:0] TIMEOUT_TICKS_RST = 16'd10;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [TriesW-1:0] tries;
    logic              ready_res;
  } res_t;

endpackage

// ===== rtl/core/ars_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ars_core
// Retry state and per-event decision logic; state advances on each step.
// ---------------------------------------------------------------------------
module ars_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [ars_pkg::FuncW-1:0]   func,
  input  logic [ars_pkg::AddrW-1:0]   addr_one,
  input  logic [ars_pkg::AddrW-1:0]   addr_two,
  input  logic [ars_pkg::TriesW-1:0]  try_limit,
  input  logic [ars_pkg::TicksW-1:0]  timeout_ticks,
  output ars_pkg::res_t               res
);
  import ars_pkg::*;

  logic              waiting, waiting_next;
  logic [AddrW-1:0]  saved_receiver, saved_transmitter;
  logic [TriesW-1:0] try_count, try_count_next;
  logic [TicksW-1:0] ticks_left, ticks_left_next;
  logic              save_addr;

  logic [TriesW-1:0] eff_tries;
  logic [TicksW-1:0] eff_timeout;
  logic [TicksW-1:0] ticks_dec;

  always_comb begin
    eff_tries   = (try_limit == '0) ? TriesW'(1) : try_limit;
    eff_timeout = (timeout_ticks == '0) ? TicksW'(1) : timeout_ticks;
    ticks_dec   = (ticks_left != '0) ? ticks_left - TicksW'(1) : ticks_left;

    waiting_next    = waiting;
    try_count_next  = try_count;
    ticks_left_next = ticks_left;
    save_addr       = 1'b0;
    res.action      = ACT_NONE;
    res.tries       = try_count;

    unique case (func)
      FUNC_TICK: begin
        if (waiting) begin
          ticks_left_next = ticks_dec;
          if (ticks_dec == '0) begin
            if (try_count >= eff_tries) begin
              res.action     = ACT_GAVE_UP;
              waiting_next   = 1'b0;
              try_count_next = '0;
            end else begin
              res.action      = ACT_RESEND;
              try_count_next  = try_count + TriesW'(1);
              ticks_left_next = eff_timeout;
              res.tries       = try_count_next;
            end
          end
        end
      end
      FUNC_FRAME: begin
        if (!waiting) begin
          res.action = ACT_SEND;
          res.tries  = TriesW'(1);
          // a limit of one sends once and keeps nothing
          if (eff_tries > TriesW'(1)) begin
            waiting_next    = 1'b1;
            save_addr       = 1'b1;
            try_count_next  = TriesW'(1);
            ticks_left_next = eff_timeout;
          end
        end else begin
          res.action = ACT_BUSY;
        end
      end
      FUNC_ACK: begin
        if (!waiting) begin
          res.action = ACT_UNEXPECTED;
        end else if (addr_two != saved_receiver || addr_one != saved_transmitter) begin
          res.action = ACT_WRONG;
        end else begin
          res.action      = ACT_ACKED;
          waiting_next    = 1'b0;
          try_count_next  = '0;
          ticks_left_next = '0;
        end
      end
      default: begin
      end
    endcase

    res.ready_res = !waiting_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting    <= 1'b0;
      try_count  <= '0;
      ticks_left <= '0;
    end else if (step) begin
      waiting    <= waiting_next;
      try_count  <= try_count_next;
      ticks_left <= ticks_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_receiver    <= '0;
      saved_transmitter <= '0;
    end else if (step && save_addr) begin
      saved_receiver    <= addr_one;
      saved_transmitter <= addr_two;
    end
  end

endmodule

// ===== rtl/core/ack_retry_sender.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ack_retry_sender
// Stop-and-wait retransmission control for one outstanding frame.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  s_*      | in  | s_tvalid / s_tready | tuser func, tdata addr_one, addr_two
//  m_*      | out | m_tvalid / m_tready | tuser action, tdata tries, ready_res
//  cfg_*    | in  | cfg_we              | cfg_index, cfg_data
//
// One event per clock sustained while results are taken; an event's result passes
// through the input register, decision logic and result register.
// Reset is synchronous and needs no clearing pass.
// A stalled result holds in the result register; the input register still
// takes one more event, then s_tready falls until the result is taken.
// ---------------------------------------------------------------------------
module ack_retry_sender (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [95:0]                   s_tdata,   // addr_one[47:0], addr_two[95:48]
  input  logic [ars_pkg::FuncW-1:0]     s_tuser,   // func[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // tries[7:0], ready_res[8], zero
  output logic [ars_pkg::ActW-1:0]      m_tuser,   // action[2:0]
  input  logic                          cfg_we,
  input  logic [ars_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ars_pkg::CfgW-1:0]      cfg_data
);
  import ars_pkg::*;

  logic [TriesW-1:0] try_limit;
  logic [TicksW-1:0] timeout_ticks;

  logic              in_valid;
  logic [FuncW-1:0]  in_func;
  logic [AddrW-1:0]  in_addr_one, in_addr_two;
  logic              step;
  res_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      try_limit     <= TRY_LIMIT_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRY_LIMIT:     try_limit     <= cfg_data[TriesW-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TicksW-1:0];
        default: begin
        end
      endcase
    end
  end

  // advance the held event only when the result register is free
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func     <= s_tuser;
      in_addr_one <= s_tdata[AddrW-1:0];
      in_addr_two <= s_tdata[2*AddrW-1:AddrW];
    end
  end

  ars_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .func          (in_func),
    .addr_one      (in_addr_one),
    .addr_two      (in_addr_two),
    .try_limit     (try_limit),
    .timeout_ticks (timeout_ticks),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tuser <= res.action;
      m_tdata <= {7'd0, res.ready_res, res.tries};
    end
  end

endmodule

// ===== rtl/core/ars_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ars_checker
// Port-level checks on the retry sender's results, bound to the top level.
// ---------------------------------------------------------------------------
`include "ack_retry_sender_assert.svh"

module ars_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [15:0]                   m_tdata,
  input logic [ars_pkg::ActW-1:0]      m_tuser
);
  import ars_pkg::*;

  logic                 m_stall;
  logic                 m_done;
  logic [ActW+15:0]     m_word;

  assign m_stall = m_tvalid && !m_tready;
  assign m_done  = m_tvalid && (m_tuser == ACT_GAVE_UP || m_tuser == ACT_ACKED);
  assign m_word  = {m_tuser, m_tdata};

  `ARS_ASSERT_ALWAYS(a_reset_idle, rst, !m_tvalid, "result valid right after reset")
  `ARS_ASSERT_NEXT(a_stall_hold, m_stall, m_tvalid && $stable(m_word), "stalled result changed")
  `ARS_ASSERT_NOW(a_send_one, m_tvalid && m_tuser == ACT_SEND, m_tdata[7:0] == 8'd1, "send try")
  `ARS_ASSERT_NOW(a_busy_not_ready, m_tvalid && m_tuser == ACT_BUSY, !m_tdata[8], "busy but ready")
  `ARS_ASSERT_NOW(a_done_ready, m_done, m_tdata[8], "finished frame left sender busy")

endmodule

bind ack_retry_sender ars_checker u_ars_checker (.*);
